// ----- src/psts_pkg.sv -----
`default_nettype none

package psts_pkg;

  // fixed field widths
  localparam int ACT_W      = 3;
  localparam int IDX_W      = 11;
  localparam int VAL_W      = 32;
  localparam int TGT_W      = 48;
  localparam int SUM_W      = 48;
  localparam int FOUND_W    = 10;
  // search remainder width: target plus one spacing plus one weighted left sum
  localparam int GOAL_W     = 50;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET       = 3'd0,
    ACT_GET       = 3'd1,
    ACT_PREFIX    = 3'd2,
    ACT_SEARCH    = 3'd3,
    ACT_SEARCH_SP = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SET_CMP,
    ST_SET_WALK,
    ST_GET_CAP,
    ST_PFX_WALK,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic rd_node;
    logic rd_sib;
    logic rd_root;
    logic set_leaf;
    logic walk_set;
    logic walk_pfx;
    logic cap;
    logic srch_rd;
    logic srch_cmp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             past;
    logic             same;
    logic             skip;
    logic             parent_root;
    logic             leaf_reached;
    logic             clr_last;
  } status_t;

endpackage

`default_nettype wire

// ----- src/psts_ram.sv -----
`default_nettype none

module psts_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/psts_datapath.sv -----
`default_nettype none

module psts_datapath #(
  parameter int LEAVES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  psts_pkg::cmd_t                     cmd,
  output psts_pkg::status_t                  sts,
  input  logic [psts_pkg::ACT_W-1:0]         in_action,
  input  logic [psts_pkg::IDX_W-1:0]         in_index,
  input  logic signed [psts_pkg::VAL_W-1:0]  in_value,
  input  logic signed [psts_pkg::TGT_W-1:0]  in_target,
  input  logic signed [psts_pkg::VAL_W-1:0]  in_spacing,
  output logic [psts_pkg::SUM_W-1:0]         out_amount,
  output logic [psts_pkg::FOUND_W-1:0]       out_found_index,
  output logic                               out_changed,
  output logic                               out_rejected
);

  import psts_pkg::*;

  localparam int LEAF_W = $clog2(LEAVES);
  localparam int NODE_W = LEAF_W + 1;
  localparam int DEPTH  = 2 * LEAVES;

  // item registers
  logic [ACT_W-1:0]         act_r;
  logic                     past_r;
  logic                     tgt_nonpos_r;
  logic signed [VAL_W-1:0]  val_r;
  logic signed [GOAL_W-1:0] goal_r;
  logic signed [GOAL_W-1:0] gsc_r;
  logic [SUM_W-1:0]         acc_r;
  logic [NODE_W-1:0]        node_r;
  logic                     changed_r;
  logic                     rejected_r;

  // result registers
  logic [SUM_W-1:0]   out_amount_r;
  logic [FOUND_W-1:0] out_found_r;
  logic               out_changed_r;
  logic               out_rejected_r;

  // node store
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  logic [SUM_W-1:0]  wr_data;
  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  logic [SUM_W-1:0]  rd_data;

  logic [LEAF_W-1:0]        leaf_in;
  logic                     past_in;
  logic                     is_sp_in;
  logic                     is_srch_in;
  logic signed [GOAL_W-1:0] tgt_ext;
  logic signed [GOAL_W-1:0] gap_ext;
  logic signed [GOAL_W-1:0] goal_init;
  logic signed [GOAL_W-1:0] gsc_init;
  logic [NODE_W-1:0]        node_up;
  logic [NODE_W-1:0]        node_sib;
  logic [NODE_W-1:0]        up_sib;
  logic [NODE_W-1:0]        node_dn;
  logic [SUM_W-1:0]         val_ext;
  logic [SUM_W-1:0]         walk_sum;
  logic signed [GOAL_W-1:0] diff;
  logic                     go_right;
  logic                     act_srch;
  logic                     act_amt;
  logic [31:0]              found_ext;

  assign leaf_in    = LEAF_W'(in_index);
  assign past_in    = (32'(in_index) >= 32'(LEAVES));
  assign is_sp_in   = (in_action == ACT_SEARCH_SP);
  assign is_srch_in = (in_action == ACT_SEARCH) || is_sp_in;
  assign tgt_ext    = GOAL_W'(in_target);
  assign gap_ext    = GOAL_W'(in_spacing);
  // spacing weighs the whole tree first, halved at every level going down
  assign goal_init  = is_sp_in ? (tgt_ext + gap_ext) : tgt_ext;
  assign gsc_init   = is_sp_in ? (gap_ext <<< LEAF_W) : '0;

  assign node_up  = node_r >> 1;
  assign node_sib = node_r ^ NODE_W'(1);
  assign up_sib   = node_up ^ NODE_W'(1);
  assign node_dn  = node_r << 1;
  assign val_ext  = SUM_W'(val_r);
  assign walk_sum = acc_r + rd_data;
  assign diff     = goal_r - gsc_r - GOAL_W'(signed'(rd_data));
  assign go_right = (diff > 0);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = node_r;
    if (cmd.rd_node) begin
      rd_en   = 1'b1;
      rd_addr = node_r;
    end else if (cmd.rd_sib) begin
      rd_en   = 1'b1;
      rd_addr = node_sib;
    end else if (cmd.rd_root) begin
      rd_en   = 1'b1;
      rd_addr = NODE_W'(1);
    end else if (cmd.walk_set || cmd.walk_pfx) begin
      rd_en   = 1'b1;
      rd_addr = up_sib;
    end else if (cmd.srch_rd) begin
      rd_en   = 1'b1;
      rd_addr = node_dn;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node_r;
    wr_data = '0;
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = node_r;
      wr_data = '0;
    end else if (cmd.set_leaf) begin
      wr_en   = 1'b1;
      wr_addr = node_r;
      wr_data = val_ext;
    end else if (cmd.walk_set) begin
      wr_en   = 1'b1;
      wr_addr = node_up;
      wr_data = walk_sum;
    end
  end

  psts_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // node pointer doubles as the sweep counter of the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r <= '0;
    end else if (cmd.clr_step) begin
      node_r <= node_r + NODE_W'(1);
    end else if (cmd.load) begin
      node_r <= is_srch_in ? NODE_W'(1) : {1'b1, leaf_in};
    end else if (cmd.walk_set || cmd.walk_pfx) begin
      node_r <= node_up;
    end else if (cmd.srch_rd) begin
      node_r <= node_dn;
    end else if (cmd.srch_cmp && go_right) begin
      node_r <= node_r | NODE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r        <= in_action;
      past_r       <= past_in;
      tgt_nonpos_r <= (in_target <= 0);
      val_r        <= in_value;
      goal_r       <= goal_init;
      gsc_r        <= gsc_init;
      acc_r        <= '0;
      changed_r    <= 1'b0;
      rejected_r   <= (in_action == ACT_SET) && past_in && (in_value != 0);
    end else begin
      if (cmd.set_leaf) begin
        changed_r <= 1'b1;
        acc_r     <= val_ext;
      end
      if (cmd.walk_set) begin
        acc_r <= walk_sum;
      end
      if (cmd.walk_pfx && node_r[0]) begin
        acc_r <= walk_sum;
      end
      if (cmd.cap) begin
        acc_r <= rd_data;
      end
      if (cmd.srch_rd) begin
        gsc_r <= gsc_r >>> 1;
      end
      if (cmd.srch_cmp && go_right) begin
        goal_r <= diff;
      end
    end
  end

  assign act_srch  = (act_r == ACT_SEARCH) || (act_r == ACT_SEARCH_SP);
  assign act_amt   = (act_r == ACT_GET) || (act_r == ACT_PREFIX);
  assign found_ext = 32'(node_r[LEAF_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_amount_r   <= act_amt ? acc_r : '0;
      out_found_r    <= (act_srch && node_r[LEAF_W]) ? found_ext[FOUND_W-1:0] : '0;
      out_changed_r  <= changed_r;
      out_rejected_r <= rejected_r;
    end
  end

  assign out_amount      = out_amount_r;
  assign out_found_index = out_found_r;
  assign out_changed     = out_changed_r;
  assign out_rejected    = out_rejected_r;

  assign sts.act          = act_r;
  assign sts.past         = past_r;
  assign sts.same         = (rd_data == val_ext);
  assign sts.skip         = tgt_nonpos_r || (goal_r <= 0);
  assign sts.parent_root  = (node_up == NODE_W'(1));
  assign sts.leaf_reached = node_r[LEAF_W];
  assign sts.clr_last     = &node_r;

endmodule

`default_nettype wire

// ----- src/psts_ctrl.sv -----
`default_nettype none

module psts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  psts_pkg::status_t sts,
  output psts_pkg::cmd_t    cmd
);

  import psts_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.act) inside
          ACT_SET:                   state_nxt = sts.past ? ST_DONE : ST_SET_CMP;
          ACT_GET:                   state_nxt = sts.past ? ST_DONE : ST_GET_CAP;
          ACT_PREFIX:                state_nxt = sts.past ? ST_GET_CAP : ST_PFX_WALK;
          ACT_SEARCH, ACT_SEARCH_SP: state_nxt = sts.skip ? ST_DONE : ST_SRCH_RD;
          default:                   state_nxt = ST_DONE;
        endcase
      end
      ST_SET_CMP: begin
        state_nxt = sts.same ? ST_DONE : ST_SET_WALK;
      end
      ST_SET_WALK, ST_PFX_WALK: begin
        if (sts.parent_root) begin
          state_nxt = ST_DONE;
        end
      end
      ST_GET_CAP: begin
        state_nxt = ST_DONE;
      end
      ST_SRCH_RD: begin
        state_nxt = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        state_nxt = sts.leaf_reached ? ST_DONE : ST_SRCH_RD;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_DISPATCH: begin
        case (sts.act) inside
          ACT_SET, ACT_GET: cmd.rd_node = !sts.past;
          ACT_PREFIX: begin
            cmd.rd_root = sts.past;
            cmd.rd_sib  = !sts.past;
          end
          default: ;
        endcase
      end
      ST_SET_CMP: begin
        cmd.set_leaf = !sts.same;
        cmd.rd_sib   = !sts.same;
      end
      ST_SET_WALK: cmd.walk_set = 1'b1;
      ST_PFX_WALK: cmd.walk_pfx = 1'b1;
      ST_GET_CAP:  cmd.cap      = 1'b1;
      ST_SRCH_RD:  cmd.srch_rd  = 1'b1;
      ST_SRCH_CMP: cmd.srch_cmp = 1'b1;
      ST_DONE:     cmd.out_load = out_free;
      default: ;
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ----- src/prefix_sum_tree_search_core.sv -----
`default_nettype none

// summation tree over LEAVES signed q16.16 leaves, kept in a 2*LEAVES x 48 node memory
// input channel (in_*): one word per action; in_tuser carries the action code
//   (0 set, 1 read leaf, 2 prefix sum, 3 search, 4 search with spacing)
// result channel (out_*): exactly one word per accepted input word, in order
// one item is worked at a time on the single read/write port pair of the node
//   memory; a set reads the leaf, writes it and walks the sums up to the root,
//   a read leaf reads and captures it, a prefix sum adds the left siblings on its
//   way up or, past capacity, reads the root, and a search reads the left child at
//   each level before it picks the next address; sets past capacity, unchanged sets
//   and skipped searches finish sooner; the next word is taken as soon as the
//   previous result sits in the output register, even if not yet taken
// reset: rst_n is synchronous; after it a clearing pass over all 2*LEAVES node
//   addresses zeroes the node memory, with in_tready low throughout
// stall: while a result waits and out_tready is low the result register holds; a
//   finished item then waits in its last step and no new word is accepted
module prefix_sum_tree_search_core #(
  parameter int LEAVES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: index[10:0], value[42:11], target[90:43], spacing[122:91], zero pad
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [psts_pkg::IN_DATA_W-1:0]      in_tdata,
  // in_tuser: action[2:0]
  input  logic [psts_pkg::ACT_W-1:0]          in_tuser,
  // out_tdata: amount[47:0], found_index[57:48], changed[58], rejected[59], zero pad
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [psts_pkg::OUT_DATA_W-1:0]     out_tdata
);

  import psts_pkg::*;

  cmd_t    cmd;
  status_t sts;

  logic [SUM_W-1:0]   amount;
  logic [FOUND_W-1:0] found_index;
  logic               changed;
  logic               rejected;

  psts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // field unpacking, lowest field first
  psts_datapath #(
    .LEAVES (LEAVES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_tuser),
    .in_index        (in_tdata[10:0]),
    .in_value        (in_tdata[42:11]),
    .in_target       (in_tdata[90:43]),
    .in_spacing      (in_tdata[122:91]),
    .out_amount      (amount),
    .out_found_index (found_index),
    .out_changed     (changed),
    .out_rejected    (rejected)
  );

  assign out_tdata = {4'b0000, rejected, changed, found_index, amount};

  // an accepted word never produces its result in the next cycle
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !$rose(out_tvalid))
    else $error("result appeared one cycle after acceptance");

  // a set cannot be both rejected and applied
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[58] && out_tdata[59]))
    else $error("changed and rejected both set");

  // a search result carries no amount
  a_found_no_amount: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[57:48] != 10'd0)) |-> (out_tdata[47:0] == 48'd0))
    else $error("found index together with nonzero amount");

  // no result rises while the block sits idle waiting for a word
  a_ready_no_new: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && !out_tvalid) |=> !out_tvalid)
    else $error("result raised from the idle state");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psts_pkg::*;

  localparam int TREE_LEAVES = 1024;
  localparam logic [IDX_W-1:0] IDX_PAST = IDX_W'(TREE_LEAVES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TREE_LEAVES - 1);
  // codes past the defined actions, treated as no-ops
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [SUM_W-1:0]   amount;
    logic [FOUND_W-1:0] found_index;
    logic               changed;
    logic               rejected;
  } tree_result_t;

  // mirror of the node memory plus the queue of results still owed by the block
  class prefix_tree_board_t;
    longint       node_sum[2*TREE_LEAVES];
    tree_result_t due_results[$];
    int           mismatches;

    function longint leaf(logic [IDX_W-1:0] idx);
      if (idx >= TREE_LEAVES) return 0;
      return node_sum[idx + TREE_LEAVES];
    endfunction

    function longint prefix_below(logic [IDX_W-1:0] idx);
      longint      acc;
      int unsigned n;
      if (idx >= TREE_LEAVES) return node_sum[1];
      acc = 0;
      n = idx + TREE_LEAVES;
      while (n > 1) begin
        if (n[0]) acc += node_sum[n ^ 1];
        n = n >> 1;
      end
      return acc;
    endfunction

    // walk from the root toward the lowest leaf whose running sum reaches goal
    function logic [FOUND_W-1:0] walk_down(longint goal, longint gap, bit with_gap);
      int unsigned node;
      int unsigned span;
      longint      left;
      node = 1;
      span = TREE_LEAVES;
      if (goal <= 0) return '0;
      if (with_gap) goal += gap;
      while (node < TREE_LEAVES && goal > 0) begin
        node = node * 2;
        span = span / 2;
        left = node_sum[node];
        if (with_gap) left += gap * longint'(span);
        if (goal > left) begin
          goal -= left;
          node += 1;
        end
      end
      if (node < TREE_LEAVES) return '0;
      return FOUND_W'(node - TREE_LEAVES);
    endfunction

    function tree_result_t predict_action(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                          logic [VAL_W-1:0] val, logic [TGT_W-1:0] tgt,
                                          logic [VAL_W-1:0] sp);
      tree_result_t res;
      longint       new_leaf;
      int unsigned  n;
      res = '0;
      new_leaf = longint'($signed(val));
      case (act)
        ACT_SET: begin
          if (idx >= TREE_LEAVES) begin
            res.rejected = (new_leaf != 0);
          end else begin
            n = idx + TREE_LEAVES;
            if (node_sum[n] != new_leaf) begin
              res.changed = 1'b1;
              node_sum[n] = new_leaf;
              n = n >> 1;
              while (n > 0) begin
                node_sum[n] = node_sum[2*n] + node_sum[2*n+1];
                n = n >> 1;
              end
            end
          end
        end
        ACT_GET:       res.amount = SUM_W'(leaf(idx));
        ACT_PREFIX:    res.amount = SUM_W'(prefix_below(idx));
        ACT_SEARCH:    res.found_index = walk_down(longint'($signed(tgt)), 0, 1'b0);
        ACT_SEARCH_SP: res.found_index = walk_down(longint'($signed(tgt)),
                                                   longint'($signed(sp)), 1'b1);
        default: ;
      endcase
      return res;
    endfunction

    function void note_word(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                            logic [VAL_W-1:0] val, logic [TGT_W-1:0] tgt,
                            logic [VAL_W-1:0] sp);
      due_results.push_back(predict_action(act, idx, val, tgt, sp));
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] w);
      tree_result_t got;
      tree_result_t want;
      got.amount      = w[47:0];
      got.found_index = w[57:48];
      got.changed     = w[58];
      got.rejected    = w[59];
      if (due_results.size() == 0) begin
        $error("result word arrived with nothing pending");
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (got.amount !== want.amount) begin
        $error("amount: expected %0d, actual %0d", $signed(want.amount), $signed(got.amount));
        mismatches++;
      end
      if (got.found_index !== want.found_index) begin
        $error("found_index: expected %0d, actual %0d", want.found_index, got.found_index);
        mismatches++;
      end
      if (got.changed !== want.changed) begin
        $error("changed: expected %0b, actual %0b", want.changed, got.changed);
        mismatches++;
      end
      if (got.rejected !== want.rejected) begin
        $error("rejected: expected %0b, actual %0b", want.rejected, got.rejected);
        mismatches++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [ACT_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  prefix_tree_board_t board = new();

  prefix_sum_tree_search_core #(
    .LEAVES(TREE_LEAVES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random back-pressure, checked at the rising edge
  initial begin
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_word(out_tdata);
  end

  task automatic push_word(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                           logic [VAL_W-1:0] val, logic [TGT_W-1:0] tgt,
                           logic [VAL_W-1:0] sp);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    // index, value, target, spacing from bit 0 up, zero pad
    in_tdata  <= {5'b0, sp, tgt, val, idx};
    do @(posedge clk); while (!in_tready);
    board.note_word(act, idx, val, tgt, sp);
  endtask

  // sender holds off until every owed word is back
  task automatic wait_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic run_random(int count);
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic [TGT_W-1:0] tgt;
    logic [VAL_W-1:0] sp;
    longint           total;
    int               r;
    repeat (count) begin
      // noise in every field, then shape what the action actually uses
      val = $urandom;
      tgt = TGT_W'({$urandom, $urandom});
      sp  = $urandom;
      r = $urandom_range(99);
      if (r < 30)      act = ACT_SET;
      else if (r < 44) act = ACT_GET;
      else if (r < 62) act = ACT_PREFIX;
      else if (r < 81) act = ACT_SEARCH;
      else if (r < 97) act = ACT_SEARCH_SP;
      else             act = ACT_LAST_SPARE();

      r = $urandom_range(99);
      if (r < 6)       idx = IDX_PAST;
      else if (r < 9)  idx = '0;
      else if (r < 12) idx = IDX_LAST;
      else             idx = IDX_W'($urandom_range(0, TREE_LEAVES - 1));

      if (act == ACT_SET) begin
        r = $urandom_range(99);
        if (r < 55)      val = VAL_W'($urandom_range(0, 1 << 20));
        else if (r < 67) val = ~VAL_W'($urandom_range(0, 1 << 18));
        else if (r < 77) val = '0;
        else if (r < 92) val = VAL_W'(board.leaf(idx));
        if (idx >= TREE_LEAVES && $urandom_range(1) == 1) val = '0;
      end

      if (act == ACT_SEARCH || act == ACT_SEARCH_SP) begin
        total = board.prefix_below(IDX_PAST);
        r = $urandom_range(99);
        if (r < 40 && total > 0)
          tgt = TGT_W'(1 + longint'({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % total);
        else if (r < 62)
          tgt = TGT_W'(board.prefix_below(IDX_W'($urandom_range(0, TREE_LEAVES - 1)))
                       + $urandom_range(0, 1));
        else if (r < 72)
          tgt = TGT_W'(-longint'($urandom_range(0, 1000)));
        else if (r < 82)
          tgt = TGT_W'(total + $urandom_range(1, 1 << 16));
        if (act == ACT_SEARCH_SP) begin
          r = $urandom_range(99);
          if (r < 25)      sp = VAL_W'($urandom_range(0, 1 << 12));
          else if (r < 40) sp = ~VAL_W'($urandom_range(0, 1 << 12));
          else if (r < 55) sp = '0;
        end
      end
      push_word(act, idx, val, tgt, sp);
    end
  endtask

  function automatic logic [ACT_W-1:0] ACT_LAST_SPARE();
    return ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
  endfunction

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty store, extremes, capacity edge, no-op codes
    push_word(ACT_GET,       '0,       32'd0,         48'd0,              32'd0);
    push_word(ACT_PREFIX,    IDX_PAST, 32'd0,         48'd0,              32'd0);
    push_word(ACT_SEARCH,    '0,       32'd0,         48'd0,              32'd0);
    push_word(ACT_SET,       '0,       32'h7fff_ffff, 48'd0,              32'd0);
    push_word(ACT_SET,       IDX_LAST, 32'h8000_0000, 48'd0,              32'd0);
    push_word(ACT_SET,       IDX_LAST, 32'h8000_0000, 48'd0,              32'd0);
    push_word(ACT_SET,       IDX_PAST, 32'd0,         48'd0,              32'd0);
    push_word(ACT_SET,       IDX_PAST, 32'h0001_0000, 48'd0,              32'd0);
    push_word(ACT_GET,       IDX_LAST, 32'd0,         48'd0,              32'd0);
    push_word(ACT_GET,       IDX_PAST, 32'd0,         48'd0,              32'd0);
    push_word(ACT_PREFIX,    IDX_LAST, 32'd0,         48'd0,              32'd0);
    push_word(ACT_PREFIX,    '0,       32'd0,         48'd0,              32'd0);
    push_word(ACT_PREFIX,    IDX_PAST, 32'd0,         48'd0,              32'd0);
    push_word(ACT_SEARCH,    '0,       32'd0,         48'h7fff_ffff_ffff, 32'd0);
    push_word(ACT_SEARCH,    '0,       32'd0,         48'h8000_0000_0000, 32'd0);
    push_word(ACT_SEARCH,    '0,       32'd0,         48'd1,              32'd0);
    push_word(ACT_SEARCH_SP, '0,       32'd0,         48'd1,              32'h7fff_ffff);
    push_word(ACT_SEARCH_SP, '0,       32'd0,         48'h7fff_ffff_ffff, 32'h8000_0000);
    push_word(ACT_SEARCH_SP, '0,       32'd0,         48'h0001_0000,      32'd0);
    push_word(ACT_SEARCH_SP, '0,       32'd0,         48'h8000_0000_0000, 32'h0000_1000);
    push_word(ACT_SPARE_LO,  IDX_W'($urandom), $urandom, TGT_W'({$urandom, $urandom}),
              $urandom);
    push_word(ACT_SPARE_HI,  IDX_W'($urandom), $urandom, TGT_W'({$urandom, $urandom}),
              $urandom);
    push_word(ACT_SET,       11'd512,  32'h0001_0000, 48'd0,              32'd0);
    push_word(ACT_SET,       '0,       32'd0,         48'd0,              32'd0);
    push_word(ACT_SET,       IDX_LAST, 32'd0,         48'd0,              32'd0);
    wait_drain();

    send_idle_pct = 31;
    recv_idle_pct = 63;
    run_random(560);
    wait_drain();

    send_idle_pct = 63;
    recv_idle_pct = 31;
    run_random(560);
    wait_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(560);
    wait_drain();

    // let any stray word show up before the verdict
    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
src/psts_pkg.sv
src/psts_ram.sv
src/psts_datapath.sv
src/psts_ctrl.sv
src/prefix_sum_tree_search_core.sv
tb/tb_top.sv
